@@ src/clra_pkg.sv @@
// ----------------------------------------------------------------------------
// clra_pkg
// shared types, constants and helpers of the cpu lend/reclaim allocator
// ----------------------------------------------------------------------------
package clra_pkg;

   localparam int MAX_PROCS = 16;
   localparam int PROC_W    = $clog2(MAX_PROCS);
   localparam int NPROC_W   = $clog2(MAX_PROCS + 1);
   localparam int CNT_W     = 9;
   localparam int NUMP_W    = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0]  CNT_MAX          = '1;
   localparam logic [NUMP_W-1:0] NUM_PROCS_RESET  = NUMP_W'(4);
   localparam logic [CNT_W-1:0]  SHARE_RESET      = CNT_W'(4);

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PROCS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE     = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_LEND    = 2'd1,
      OP_ACQUIRE = 2'd2,
      OP_ASK     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_HOLDING = 2'd1,
      ST_SHORT   = 2'd2
   } status_type;

   // one datapath action per cycle
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_START_STEP,
      DP_LEND,
      DP_ASK,
      DP_ACQ_HEAD,
      DP_ACQ_STEP,
      DP_ACQ_FINAL,
      DP_DRAIN
   } dp_cmd_type;

   typedef struct packed {
      logic req_in_range;   // process of the offered word is below the process count
      logic start_last;     // start walk sits on the last process
      logic holding;        // requester already holds cpus
      logic walk_done;      // nothing missing any more or walk wrapped to requester
      logic drain_last;     // result being shown is the final one
   } dp_sts_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

endpackage

@@ src/cpu_lend_reclaim_allocator.sv @@
// ----------------------------------------------------------------------------
// cpu_lend_reclaim_allocator
// per-process cpu count table with an idle pool, sending count updates
// ----------------------------------------------------------------------------
// One event word is taken at a time; req_tready is high only while the block
// is idle. Each event is worked through one table entry per cycle by a shared
// datapath, and its updates are collected in a sixteen-entry result buffer,
// because the status carried by every update of an event is known only at its
// end. The buffer is then drained, one word per cycle while rsp_tready is
// high, with tlast on the final update. Every event spends the cycle it is
// accepted in idle, where the datapath latches the process. Start then writes
// the share into each of the n table entries (n = process count clamped to
// 1..16) and sends n output words. Lend and ask each make a single table
// update and send one output word. Acquire takes a head step, a walk over at
// most the n-1 other processes and a closing step, plus one word per update
// (at most n); a requester that already holds cpus skips the walk and the
// closing step. The drain stalls while rsp_tready is low. An event other than
// start for a process at or above the process count is dropped in the
// accepting cycle with no output.
// Configuration writes are always taken (csr_ready is tied high) and belong
// in idle periods only.
// ----------------------------------------------------------------------------
module cpu_lend_reclaim_allocator
   import clra_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // config write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data,
   // event words
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // op[1:0], process[5:2], zero[7:6]
   // update words
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // target[3:0], cpu_count[12:4], zero[15:13]
   output logic [1:0]           rsp_tuser,   // status[1:0]
   output logic                 rsp_tlast
);

   logic [NUMP_W-1:0]  num_procs_ff;
   logic [CNT_W-1:0]   share_ff;
   logic [NPROC_W-1:0] procs_used;

   op_type             req_op;
   logic [3:0]         req_process;
   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic [3:0]         rsp_target;
   logic [CNT_W-1:0]   rsp_cpu_count;
   status_type         rsp_status;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_procs_ff <= NUM_PROCS_RESET;
         share_ff     <= SHARE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_PROCS: num_procs_ff <= csr_data[NUMP_W-1:0];
            CSR_SHARE:     share_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // process count clamped to the table size, at least one
   always_comb begin
      if (num_procs_ff == '0) begin
         procs_used = NPROC_W'(1);
      end else if (32'(num_procs_ff) > MAX_PROCS) begin
         procs_used = NPROC_W'(MAX_PROCS);
      end else begin
         procs_used = NPROC_W'(num_procs_ff);
      end
   end

   assign req_op      = op_type'(req_tdata[1:0]);
   assign req_process = req_tdata[5:2];

   clra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   clra_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_process   (req_process),
      .procs_used    (procs_used),
      .share         (share_ff),
      .sts           (sts),
      .rsp_target    (rsp_target),
      .rsp_cpu_count (rsp_cpu_count),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_cpu_count, rsp_target};
   assign rsp_tuser = rsp_status;

endmodule

@@ src/clra_ctrl.sv @@
// ----------------------------------------------------------------------------
// clra_ctrl
// event sequencer: picks one datapath action per cycle
// ----------------------------------------------------------------------------
module clra_ctrl
   import clra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  op_type     req_op,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_LEND,
      S_ASK,
      S_ACQ_HEAD,
      S_ACQ_WALK,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_START) begin
                  cmd      = DP_LOAD;
                  state_in = S_START;
               end else if (sts.req_in_range) begin
                  cmd = DP_LOAD;
                  case (req_op)
                     OP_LEND:    state_in = S_LEND;
                     OP_ASK:     state_in = S_ASK;
                     OP_ACQUIRE: state_in = S_ACQ_HEAD;
                     default:    state_in = S_IDLE;
                  endcase
               end
            end
         end
         S_START: begin
            cmd = DP_START_STEP;
            if (sts.start_last) state_in = S_DRAIN;
         end
         S_LEND: begin
            cmd      = DP_LEND;
            state_in = S_DRAIN;
         end
         S_ASK: begin
            cmd      = DP_ASK;
            state_in = S_DRAIN;
         end
         S_ACQ_HEAD: begin
            cmd      = DP_ACQ_HEAD;
            state_in = sts.holding ? S_DRAIN : S_ACQ_WALK;
         end
         S_ACQ_WALK: begin
            if (sts.walk_done) begin
               cmd      = DP_ACQ_FINAL;
               state_in = S_DRAIN;
            end else begin
               cmd = DP_ACQ_STEP;
            end
         end
         S_DRAIN: begin
            if (rsp_tready) begin
               cmd = DP_DRAIN;
               if (sts.drain_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DRAIN);

endmodule

@@ src/clra_dpath.sv @@
// ----------------------------------------------------------------------------
// clra_dpath
// cpu table, idle pool, walk index and result buffer
// ----------------------------------------------------------------------------
module clra_dpath
   import clra_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  op_type             req_op,
   input  logic [3:0]         req_process,
   input  logic [NPROC_W-1:0] procs_used,
   input  logic [CNT_W-1:0]   share,
   output dp_sts_type         sts,
   output logic [3:0]         rsp_target,
   output logic [CNT_W-1:0]   rsp_cpu_count,
   output status_type         rsp_status,
   output logic               rsp_last
);

   logic [CNT_W-1:0]   table_ff [MAX_PROCS];
   logic [CNT_W-1:0]   pool_ff, pool_in;
   logic [PROC_W-1:0]  proc_ff, proc_in;
   logic [PROC_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   missing_ff, missing_in;
   status_type         status_ff, status_in;
   logic [NPROC_W-1:0] wr_cnt_ff, wr_cnt_in;
   logic [PROC_W-1:0]  rd_ptr_ff, rd_ptr_in;

   // result buffer, drained once the event's status is known
   logic [PROC_W-1:0]  buf_tgt_ff [MAX_PROCS];
   logic [CNT_W-1:0]   buf_cnt_ff [MAX_PROCS];

   logic               tbl_we;
   logic [PROC_W-1:0]  tbl_addr;
   logic [CNT_W-1:0]   tbl_wdata;
   logic               push;
   logic [PROC_W-1:0]  push_tgt;
   logic [CNT_W-1:0]   push_cnt;

   logic [CNT_W-1:0]   tbl_rd;
   logic [CNT_W-1:0]   excess;
   logic [PROC_W-1:0]  idx_next;
   logic [PROC_W-1:0]  proc_req;

   function automatic logic [PROC_W-1:0] wrap_inc(input logic [PROC_W-1:0] i,
                                                  input logic [NPROC_W-1:0] n);
      logic [NPROC_W-1:0] s;
      s = NPROC_W'(i) + NPROC_W'(1);
      return (s >= n) ? '0 : s[PROC_W-1:0];
   endfunction

   assign proc_req = PROC_W'(req_process);
   assign tbl_rd   = table_ff[idx_ff];
   assign excess   = tbl_rd - share;
   assign idx_next = wrap_inc(idx_ff, procs_used);

   assign sts.req_in_range = ({1'b0, req_process} < 5'(procs_used));
   assign sts.start_last   = (NPROC_W'(idx_ff) + NPROC_W'(1) == procs_used);
   assign sts.holding      = (tbl_rd != '0);
   assign sts.walk_done    = (missing_ff == '0) || (idx_ff == proc_ff);
   assign sts.drain_last   = (NPROC_W'(rd_ptr_ff) + NPROC_W'(1) == wr_cnt_ff);

   assign rsp_target    = 4'(buf_tgt_ff[rd_ptr_ff]);
   assign rsp_cpu_count = buf_cnt_ff[rd_ptr_ff];
   assign rsp_status    = status_ff;
   assign rsp_last      = sts.drain_last;

   always_comb begin
      pool_in    = pool_ff;
      proc_in    = proc_ff;
      idx_in     = idx_ff;
      missing_in = missing_ff;
      status_in  = status_ff;
      wr_cnt_in  = wr_cnt_ff;
      rd_ptr_in  = rd_ptr_ff;
      tbl_we     = 1'b0;
      tbl_addr   = idx_ff;
      tbl_wdata  = '0;
      push       = 1'b0;
      push_tgt   = idx_ff;
      push_cnt   = '0;
      case (cmd)
         DP_LOAD: begin
            proc_in   = proc_req;
            idx_in    = (req_op == OP_START) ? '0 : proc_req;
            wr_cnt_in = '0;
            rd_ptr_in = '0;
            status_in = ST_OK;
         end
         DP_START_STEP: begin
            tbl_we    = 1'b1;
            tbl_wdata = share;
            push      = 1'b1;
            push_cnt  = share;
            pool_in   = '0;
            idx_in    = idx_next;
         end
         DP_LEND: begin
            push     = 1'b1;
            push_cnt = '0;
            pool_in  = sat_add(pool_ff, tbl_rd);
            tbl_we   = 1'b1;
         end
         DP_ASK: begin
            tbl_we    = 1'b1;
            tbl_wdata = sat_add(tbl_rd, pool_ff);
            pool_in   = '0;
            push      = 1'b1;
            push_cnt  = tbl_wdata;
         end
         DP_ACQ_HEAD: begin
            push     = 1'b1;
            push_cnt = share;
            if (tbl_rd != '0) begin
               status_in = ST_HOLDING;
            end else if (pool_ff >= share) begin
               pool_in    = pool_ff - share;
               missing_in = '0;
               idx_in     = idx_next;
            end else begin
               missing_in = share - pool_ff;
               pool_in    = '0;
               idx_in     = idx_next;
            end
         end
         DP_ACQ_STEP: begin
            if (tbl_rd > share) begin
               tbl_we = 1'b1;
               if (missing_ff > excess) begin
                  missing_in = missing_ff - excess;
                  tbl_wdata  = share;
               end else begin
                  missing_in = '0;
                  tbl_wdata  = tbl_rd - missing_ff;
               end
               push     = 1'b1;
               push_cnt = tbl_wdata;
            end
            idx_in = idx_next;
         end
         DP_ACQ_FINAL: begin
            tbl_we    = 1'b1;
            tbl_addr  = proc_ff;
            tbl_wdata = share;
            status_in = (missing_ff != '0) ? ST_SHORT : ST_OK;
         end
         DP_DRAIN: begin
            rd_ptr_in = rd_ptr_ff + PROC_W'(1);
         end
         default: begin
         end
      endcase
      if (push) wr_cnt_in = wr_cnt_ff + NPROC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff   <= '0;
         status_ff <= ST_OK;
         wr_cnt_ff <= '0;
         rd_ptr_ff <= '0;
         for (int k = 0; k < MAX_PROCS; k++) begin
            table_ff[k] <= '0;
         end
      end else begin
         pool_ff   <= pool_in;
         status_ff <= status_in;
         wr_cnt_ff <= wr_cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         if (tbl_we) table_ff[tbl_addr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff    <= proc_in;
      idx_ff     <= idx_in;
      missing_ff <= missing_in;
      if (push) begin
         buf_tgt_ff[wr_cnt_ff[PROC_W-1:0]] <= push_tgt;
         buf_cnt_ff[wr_cnt_ff[PROC_W-1:0]] <= push_cnt;
      end
   end

endmodule
